// ===== design/aes_pkg.sv =====
// Package for the AES-128 ECB/CBC engine: types, codes, S-box tables and
// round helper functions. Depends on nothing.
package aes_pkg;

    localparam int Rounds = 10;
    localparam int RkAw   = 4;

    typedef enum logic [1:0] {
        MODE_ECB_ENC = 2'd0,
        MODE_ECB_DEC = 2'd1,
        MODE_CBC_ENC = 2'd2,
        MODE_CBC_DEC = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_KEY_HI = 3'd1,
        CFG_KEY_LO = 3'd2,
        CFG_IV_HI  = 3'd3,
        CFG_IV_LO  = 3'd4
    } cfg_idx_t;

    // Controller to datapath commands
    typedef struct packed {
        logic            key_start;  // load key into schedule register
        logic            key_step;   // advance schedule one round, store key
        logic            blk_load;   // capture input beat
        logic            whiten;     // xor state with the whitening key
        logic            round_en;   // run one cipher round
        logic            last_round; // round without (inv)mix columns
        logic            finish;     // form result, update chain
        logic [RkAw-1:0] rk_addr;    // round key read address
    } aes_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        byte_of = s[127-8*i -: 8];
    endfunction

    // SubBytes, ShiftRows, optional MixColumns
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, x;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127-8*(i+4*c) -: 8] = SBOX[byte_of(s, i + 4*((c+i) & 3))];
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = byte_of(t, 4*c);   a1 = byte_of(t, 4*c+1);
                a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[127-8*(4*c)   -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
                t[127-8*(4*c+1) -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
                t[127-8*(4*c+2) -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
                t[127-8*(4*c+3) -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        enc_round = t;
    endfunction

    // InvShiftRows and InvSubBytes
    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127-8*(i+4*((c+i) & 3)) -: 8] = INV_SBOX[byte_of(s, i+4*c)];
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, u, v;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, 4*c);   a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2); a3 = byte_of(s, 4*c+3);
            // Fold the inverse matrix into a forward mix of a preconditioned column
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
            u = a0 ^ a1 ^ a2 ^ a3;
            t[127-8*(4*c)   -: 8] = a0 ^ u ^ xtime(a0 ^ a1);
            t[127-8*(4*c+1) -: 8] = a1 ^ u ^ xtime(a1 ^ a2);
            t[127-8*(4*c+2) -: 8] = a2 ^ u ^ xtime(a2 ^ a3);
            t[127-8*(4*c+3) -: 8] = a3 ^ u ^ xtime(a3 ^ a0);
        end
        inv_mix = t;
    endfunction

    // One step of the key schedule
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        key_next = {w0, w1, w2, w3};
    endfunction

endpackage

// ===== design/aes_stream_if.sv =====
// Valid/ready stream interface carrying one beat of payload.
// Depends on nothing.
interface aes_stream_if #(parameter int Width = 8);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/aes128_ecb_cbc_engine_unit.sv =====
// AES-128 ECB/CBC engine top level.
// Depends on aes_pkg, aes_stream_if, aes_ctrl, aes_datapath.
//
// Use: write mode, key and IV through the cfg port while idle, then stream
// 128-bit blocks on in_ch (block_hi, block_lo, first_block, last_block).
// Each beat yields one result beat on out_ch (result_hi, result_lo,
// result_last). first_block reloads the CBC chain from the IV.
// After accept a block takes one whitening step and ten rounds, the result
// registered with the last round. One block is in flight, so a new block
// is taken only once the engine is back in the idle state that accepts;
// this is set by the single shared round unit and the round key RAM read.
// A key write starts an expansion sweep into the round key RAM once the
// engine is idle after the write; no block is taken during it.
// Reset: mode, key, IV and chain clear; the zero key is expanded first.
// Stall: a held result stays on out_ch and blocks the input; a new block
// is taken only once the held beat is taken, at the earliest in that cycle.
module aes128_ecb_cbc_engine_unit (
    input  logic         clk,
    input  logic         rst_n,
    aes_stream_if.sink   in_ch,
    aes_stream_if.source out_ch,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [63:0]  cfg_data
);
    import aes_pkg::*;

    logic [1:0]  mode_reg;
    logic [63:0] key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic        key_wr;
    aes_cmd_t    cmd;

    assign key_wr = cfg_we && (cfg_idx == CFG_KEY_HI || cfg_idx == CFG_KEY_LO);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ECB_ENC;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            iv_hi_reg  <= '0;
            iv_lo_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MODE:   mode_reg   <= cfg_data[1:0];
                CFG_KEY_HI: key_hi_reg <= cfg_data;
                CFG_KEY_LO: key_lo_reg <= cfg_data;
                CFG_IV_HI:  iv_hi_reg  <= cfg_data;
                CFG_IV_LO:  iv_lo_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_wr    (key_wr),
        .mode      (mode_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    aes_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .mode     (mode_reg),
        .key      ({key_hi_reg, key_lo_reg}),
        .iv       ({iv_hi_reg, iv_lo_reg}),
        .in_data  (in_ch.data),
        .out_data (out_ch.data)
    );
endmodule

// ===== design/aes_ram.sv =====
// Generic single-port-write RAM with registered read.
// Depends on nothing.
module aes_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/aes_datapath.sv =====
// Datapath of the AES engine: key schedule, round key RAM, state register,
// chain register and result register. Depends on aes_pkg and aes_ram.
module aes_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  aes_pkg::aes_cmd_t cmd,
    input  logic [1:0]        mode,
    input  logic [127:0]      key,
    input  logic [127:0]      iv,
    input  logic [129:0]      in_data,
    output logic [128:0]      out_data
);
    import aes_pkg::*;

    logic [127:0]    sched_reg, sched_next;
    logic [7:0]      rcon_reg, rcon_next;
    logic [RkAw-1:0] waddr_reg, waddr_next;
    logic [127:0]    rk_wdata, rk;
    logic [127:0]    state_reg, state_next;
    logic [127:0]    chain_reg, chain_next;
    logic [127:0]    blk_reg;
    logic            last_reg;
    logic [128:0]    res_reg;
    logic [127:0]    pre, chain_cur, rnd, fin;
    logic            dec;

    assign dec = mode[0];

    // Schedule: store the plain round keys 0..10; decryption reads them in reverse
    always_comb
    begin
        sched_next = sched_reg;
        rcon_next  = rcon_reg;
        waddr_next = waddr_reg;
        rk_wdata   = sched_reg;
        if (cmd.key_start)
        begin
            sched_next = key;
            rcon_next  = 8'h01;
            waddr_next = '0;
        end
        else if (cmd.key_step)
        begin
            sched_next = key_next(sched_reg, rcon_reg);
            rcon_next  = xtime(rcon_reg);
            waddr_next = waddr_reg + 1'b1;
        end
    end

    aes_ram #(.Width(128), .Depth(Rounds + 1)) u_rk_ram (
        .clk   (clk),
        .we    (cmd.key_step),
        .waddr (waddr_reg),
        .wdata (rk_wdata),
        .raddr (cmd.rk_addr),
        .rdata (rk)
    );

    // Chain value, reloaded from IV on a first block
    assign chain_cur = in_data[1] ? iv : chain_reg;
    assign pre = (mode == MODE_CBC_ENC) ? (in_data[129:2] ^ chain_cur) : in_data[129:2];

    // Round function; decrypt applies key then inverse mix
    always_comb
    begin
        if (dec)
        begin
            rnd = inv_sub_shift(state_reg) ^ rk;
            if (!cmd.last_round)
            begin
                rnd = inv_mix(rnd);
            end
        end
        else
        begin
            rnd = enc_round(state_reg, !cmd.last_round) ^ rk;
        end
    end

    // Whitening key arrives in the cycle after load, so load parks the unwhitened block;
    // the result is taken from the last round as it is computed
    always_comb
    begin
        state_next = state_reg;
        chain_next = chain_reg;
        if (cmd.blk_load)
        begin
            state_next = pre;
            chain_next = chain_cur;
        end
        else if (cmd.whiten)
        begin
            state_next = state_reg ^ rk;
        end
        else if (cmd.round_en)
        begin
            state_next = rnd;
        end
        fin = (mode == MODE_CBC_DEC) ? (rnd ^ chain_reg) : rnd;
        if (cmd.finish && mode[1])
        begin
            chain_next = dec ? blk_reg : rnd;
        end
    end

    // Hold chain and schedule counters here, state, keys and result in the next block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            rcon_reg  <= 8'h01;
            waddr_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            rcon_reg  <= rcon_next;
            waddr_reg <= waddr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        state_reg <= state_next;
        if (cmd.blk_load)
        begin
            blk_reg  <= in_data[129:2];
            last_reg <= in_data[0];
        end
        if (cmd.finish)
        begin
            res_reg <= {fin, last_reg};
        end
    end

    assign out_data = res_reg;
endmodule

// ===== design/aes_ctrl.sv =====
// Controller of the AES engine: key expansion sweep, round sequencing,
// handshakes. Depends on aes_pkg.
module aes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_wr,
    input  logic [1:0]        mode,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output aes_pkg::aes_cmd_t cmd
);
    import aes_pkg::*;

    typedef enum logic [3:0] {
        ST_KEY  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_WHT  = 4'b0100,
        ST_RND  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [RkAw-1:0] cnt_reg, cnt_next;
    logic            kpend_reg, kpend_next;
    logic            ovld_reg, ovld_next;
    logic            dec;
    logic            out_free;

    assign dec      = mode[0];
    assign out_free = !ovld_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && !kpend_reg && out_free;
    assign out_valid = ovld_reg;

    // Sequence: key sweep of 11 writes, whitening read, 10 rounds
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kpend_next = kpend_reg || key_wr;
        ovld_next  = ovld_reg && !out_ready;
        cmd        = '0;
        cmd.rk_addr = dec ? RkAw'(Rounds) : '0;
        unique case (state_reg)
            ST_KEY:
            begin
                cmd.key_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RkAw'(Rounds))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (kpend_reg)
                begin
                    cmd.key_start = 1'b1;
                    kpend_next = key_wr;
                    cnt_next   = '0;
                    state_next = ST_KEY;
                end
                else if (in_valid && out_free)
                begin
                    cmd.blk_load = 1'b1;
                    state_next = ST_WHT;
                end
            end
            ST_WHT:
            begin
                // Whitening: xor state with the first key read during load
                cmd.whiten  = 1'b1;
                cmd.rk_addr = dec ? RkAw'(Rounds - 1) : RkAw'(1);
                cnt_next   = RkAw'(1);
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.round_en   = 1'b1;
                cmd.last_round = (cnt_reg == RkAw'(Rounds));
                cmd.rk_addr    = dec ? RkAw'(Rounds - 1) - cnt_reg : cnt_reg + 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == RkAw'(Rounds))
                begin
                    cmd.finish = 1'b1;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            kpend_reg <= 1'b1;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kpend_reg <= kpend_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Check state encoding and handshake rules
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid);
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE);
    a_load_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.blk_load |-> in_valid && in_ready);
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !ovld_reg);
endmodule

// ===== bench/aes128_ecb_cbc_engine_unit_check.sv =====
`timescale 1ns / 100ps
// Scoreboard for the AES-128 ECB/CBC engine: tracks configuration writes,
// predicts each result block and compares it. Depends on aes_pkg for codes.
module aes128_ecb_cbc_engine_unit_check
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [129:0] in_data,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [128:0] out_data,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_idx,
    input  logic [63:0]  cfg_data,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        last;
    } cipher_beat_t;

    cipher_beat_t  expected_blocks[$];
    logic [7:0]    fwd_sub[256];
    logic [7:0]    rev_sub[256];
    mode_t         cur_mode;
    logic [63:0]   key_h, key_l, iv_h, iv_l;
    logic [127:0]  chain;
    logic [127:0]  sched[11];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                p = p ^ a;
            a = dbl(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    // Build the S-box from the field inverse and the affine map
    initial
    begin
        logic [7:0] inv, q;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++)
                inv = gf_mul(inv, x[7:0]);
            if (x == 0)
                inv = 8'h00;
            q = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_sub[x] = q;
            rev_sub[q] = x[7:0];
        end
    end

    task automatic expand_schedule();
        logic [31:0] w0, w1, w2, w3, t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched[0] = {key_h, key_l};
        for (int r = 1; r <= 10; r++)
        begin
            {w0, w1, w2, w3} = sched[r-1];
            t = {fwd_sub[w3[23:16]] ^ rc, fwd_sub[w3[15:8]], fwd_sub[w3[7:0]],
                 fwd_sub[w3[31:24]]};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            sched[r] = {w0, w1, w2, w3};
            rc = dbl(rc);
        end
    endtask

    function automatic logic [127:0] cipher_fwd(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, x;
        s = s ^ sched[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(i+4*c) -: 8] = fwd_sub[byte_at(s, i + 4*((c+i) & 3))];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = byte_at(t, 4*c);
                    a1 = byte_at(t, 4*c+1);
                    a2 = byte_at(t, 4*c+2);
                    a3 = byte_at(t, 4*c+3);
                    x  = a0 ^ a1 ^ a2 ^ a3;
                    t[127-8*(4*c) -: 8]   = a0 ^ x ^ dbl(a0 ^ a1);
                    t[127-8*(4*c+1) -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
                    t[127-8*(4*c+2) -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
                    t[127-8*(4*c+3) -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
                end
            end
            s = t ^ sched[r];
        end
        return s;
    endfunction

    function automatic logic [127:0] cipher_inv(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        s = s ^ sched[10];
        for (int r = 9; r >= 0; r--)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[127-8*(i+4*((c+i) & 3)) -: 8] = rev_sub[byte_at(s, i + 4*c)];
            s = t ^ sched[r];
            if (r != 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = byte_at(s, 4*c);
                    a1 = byte_at(s, 4*c+1);
                    a2 = byte_at(s, 4*c+2);
                    a3 = byte_at(s, 4*c+3);
                    s[127-8*(4*c) -: 8]   = gf_mul(a0, 14) ^ gf_mul(a1, 11)
                                          ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                    s[127-8*(4*c+1) -: 8] = gf_mul(a0, 9) ^ gf_mul(a1, 14)
                                          ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                    s[127-8*(4*c+2) -: 8] = gf_mul(a0, 13) ^ gf_mul(a1, 9)
                                          ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                    s[127-8*(4*c+3) -: 8] = gf_mul(a0, 11) ^ gf_mul(a1, 13)
                                          ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
                end
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Work out the result block of one accepted input beat
    task automatic predict_block(input logic [129:0] d);
        logic [127:0] blk, s;
        cipher_beat_t e;
        blk = d[129:2];
        if (d[1])
            chain = {iv_h, iv_l};
        case (cur_mode)
            MODE_ECB_ENC: s = cipher_fwd(blk);
            MODE_ECB_DEC: s = cipher_inv(blk);
            MODE_CBC_ENC:
            begin
                s = cipher_fwd(blk ^ chain);
                chain = s;
            end
            default:
            begin
                s = cipher_inv(blk) ^ chain;
                chain = blk;
            end
        endcase
        e.hi = s[127:64];
        e.lo = s[63:0];
        e.last = d[0];
        expected_blocks.push_back(e);
    endtask

    assign pending = expected_blocks.size();

    // Track registers, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        cipher_beat_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            cur_mode = MODE_ECB_ENC;
            key_h = '0;
            key_l = '0;
            iv_h = '0;
            iv_l = '0;
            chain = '0;
            expected_blocks.delete();
            expand_schedule();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_MODE:   cur_mode = mode_t'(cfg_data[1:0]);
                    CFG_KEY_HI: begin key_h = cfg_data; expand_schedule(); end
                    CFG_KEY_LO: begin key_l = cfg_data; expand_schedule(); end
                    CFG_IV_HI:  iv_h = cfg_data;
                    CFG_IV_LO:  iv_l = cfg_data;
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                predict_block(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    report_mismatch("unexpected result beat", out_data[128:65], '0);
                end
                else
                begin
                    e = expected_blocks.pop_front();
                    if (out_data[128:65] !== e.hi)
                        report_mismatch("result_hi", out_data[128:65], e.hi);
                    if (out_data[64:1] !== e.lo)
                        report_mismatch("result_lo", out_data[64:1], e.lo);
                    if (out_data[0] !== e.last)
                        report_mismatch("result_last", {63'd0, out_data[0]}, {63'd0, e.last});
                end
            end
        end
    end

endmodule

// ===== bench/aes128_ecb_cbc_engine_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the AES-128 ECB/CBC engine bench: clock, reset, stimulus and verdict.
// Depends on aes_pkg, aes_stream_if, the engine and its scoreboard.
module aes128_ecb_cbc_engine_unit_test;
    import aes_pkg::*;

    localparam logic [2:0] CfgUnused  = 3'd7;
    localparam logic [2:0] CfgBeyond  = 3'd5;
    localparam int         IdleLimit  = 3000;
    localparam int         DrainWait  = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;
    int          snd_idle;
    int          rcv_idle;
    int          quiet_cycles;
    int          sent;

    aes_stream_if #(.Width(130)) in_ch();
    aes_stream_if #(.Width(129)) out_ch();

    aes128_ecb_cbc_engine_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    aes128_ecb_cbc_engine_unit_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_data    (in_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Randomly stall the result side
    always @(negedge clk)
        out_ch.ready = ($urandom_range(99) >= rcv_idle);

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Wait for every expected result, then let the engine settle
    task automatic drain();
        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (DrainWait) @(negedge clk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic first, input logic last);
        while ($urandom_range(99) < snd_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = {hi, lo, first, last};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Short directed part: known vector, extremes, every mode, odd cases
    task automatic run_directed();
        // zero key straight from reset
        send_block('0, '0, 1'b0, 1'b0);
        send_block('1, '1, 1'b1, 1'b1);
        drain();
        write_reg(CFG_KEY_HI, 64'h0001020304050607);
        write_reg(CFG_KEY_LO, 64'h08090a0b0c0d0e0f);
        write_reg(CFG_IV_HI, '1);
        write_reg(CFG_IV_LO, 64'h0123456789abcdef);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
        drain();
        write_reg(CFG_MODE, {62'h3fff_ffff_ffff_fffd, MODE_ECB_DEC});
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0, 1'b1);
        send_block('1, '0, 1'b1, 1'b0);
        drain();
        write_reg(CFG_MODE, MODE_CBC_ENC);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
        send_block('0, '0, 1'b0, 1'b0);
        send_block('1, '1, 1'b0, 1'b1);
        drain();
        // switch direction mid-chain; the chain register is shared
        write_reg(CFG_MODE, MODE_CBC_DEC);
        write_reg(CfgUnused, '1);
        write_reg(CfgBeyond, '1);
        send_block('1, '0, 1'b0, 1'b0);
        send_block('0, '1, 1'b0, 1'b1);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, 1'b1);
        drain();
        write_reg(CFG_KEY_HI, '1);
        write_reg(CFG_KEY_LO, '1);
        write_reg(CFG_IV_HI, '0);
        write_reg(CFG_IV_LO, '0);
        send_block('1, '1, 1'b1, 1'b0);
        send_block('0, '0, 1'b0, 1'b1);
        drain();
    endtask

    // Random config, then messages with random content and some noise
    task automatic run_random(input int quota);
        int  n, pick;
        while (quota > 0)
        begin
            write_reg(CFG_MODE, rand64());
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                write_reg(CFG_KEY_HI, pick == 0 ? '0 : (pick == 1 ? '1 : rand64()));
                write_reg(CFG_KEY_LO, pick == 0 ? '0 : (pick == 1 ? '1 : rand64()));
            end
            write_reg(CFG_IV_HI, rand64());
            write_reg(CFG_IV_LO, $urandom_range(9) == 0 ? '1 : rand64());
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(9) < 8)
                begin
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        send_block(rand64(), rand64(), k == 0, k == n - 1);
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        send_block(rand64(), rand64(), 1'($urandom_range(1)),
                                   1'($urandom_range(1)));
                end
                quota -= n;
            end
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_MODE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        sent = 0;
        snd_idle = 24;
        rcv_idle = 82;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random(550);
        snd_idle = 82;
        rcv_idle = 24;
        run_random(550);
        snd_idle = 0;
        rcv_idle = 0;
        run_random(550);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
